### hdl/tla_pkg.sv
// tla_pkg: shared widths, register indexes, reset values and the
// controller/datapath command and status structs of the track length accumulator.
// No dependencies.
package tla_pkg;

  // input word fields
  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int ELE_W = 25;
  localparam int IN_TDATA_W = 88;

  // result word fields
  localparam int LEN_W = 48;
  localparam int DIR_W = 40;
  localparam int RATIO_W = 32;
  localparam int RATIO_FRAC = 16;
  localparam int OUT_TDATA_W = 120;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [DIR_W-1:0] DIR_MAX = {DIR_W{1'b1}};
  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

  // configuration registers
  localparam int CFG_W = 24;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LON_SCALE = 1'd1;
  localparam logic [CFG_W-1:0] LAT_SCALE_RST = 24'd728312;
  localparam logic [CFG_W-1:0] LON_SCALE_RST = 24'd448266;

  // squaring sequence: which coordinate, which partial product
  localparam logic [1:0] VAR_Y = 2'd0;
  localparam logic [1:0] VAR_X = 2'd1;
  localparam logic [1:0] VAR_Z = 2'd2;
  localparam logic [1:0] PART_LL = 2'd0;
  localparam logic [1:0] PART_LH = 2'd1;
  localparam logic [1:0] PART_HH = 2'd2;

  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic       load_first;   // first = prev = current point, mark track open
    logic       sel_first;    // distance to first point instead of previous
    logic       do_diff;
    logic       do_scale;
    logic       do_sq;
    logic [1:0] sq_var;
    logic [1:0] sq_part;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       acc_add;      // add segment, prev = current
    logic       dir_load;
    logic       div_step;
    logic       load_out;
    logic       clear_track;
  } cmd_t;

  typedef struct packed {
    logic have_first;
    logic last;
    logic out_busy;
    logic dir_zero;
    logic ratio_ovf;
  } sts_t;

endpackage

### hdl/tla_dpath.sv
// tla_dpath: point registers, scale multipliers, shared squaring multiplier,
// bit-serial square root, length accumulator, ratio divider and result register.
// Depends on tla_pkg.
module tla_dpath #(
  parameter int SCALE_FRAC_BITS = 16,
  parameter int ROOT_W = 42
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_fire,
  input  logic [tla_pkg::LAT_W-1:0]        in_lat,
  input  logic [tla_pkg::LON_W-1:0]        in_lon,
  input  logic [tla_pkg::ELE_W-1:0]        in_ele,
  input  logic                             in_last,
  input  logic                             cfg_we,
  input  logic [tla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tla_pkg::CFG_W-1:0]        cfg_data,
  input  tla_pkg::cmd_t                    cmd,
  output tla_pkg::sts_t                    sts,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [tla_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tuser
);

  localparam int MLAT_W = tla_pkg::LAT_W + 1;
  localparam int MLON_W = tla_pkg::LON_W + 1;
  localparam int MELE_W = tla_pkg::ELE_W + 1;
  localparam int PY_W = MLAT_W + tla_pkg::CFG_W;
  localparam int PX_W = MLON_W + tla_pkg::CFG_W;
  localparam int V_W = ROOT_W - 1;
  localparam int H = (V_W + 1) / 2;
  localparam int SQ_W = 2 * ROOT_W;
  localparam int SH_W = $clog2(SQ_W);
  localparam int RM_W = ROOT_W + 2;
  localparam int CW = (ROOT_W > tla_pkg::LEN_W) ? ROOT_W : tla_pkg::LEN_W;
  localparam int DW = (ROOT_W > tla_pkg::DIR_W) ? ROOT_W : tla_pkg::DIR_W;

  // configuration
  logic [tla_pkg::CFG_W-1:0] lat_scale_r, lon_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_scale_r <= tla_pkg::LAT_SCALE_RST;
      lon_scale_r <= tla_pkg::LON_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tla_pkg::REG_LAT_SCALE: lat_scale_r <= cfg_data;
        tla_pkg::REG_LON_SCALE: lon_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // point registers
  logic [tla_pkg::LAT_W-1:0] cur_lat_r, anchor_lat_r, trail_lat_r;
  logic [tla_pkg::LON_W-1:0] cur_lon_r, anchor_lon_r, trail_lon_r;
  logic [tla_pkg::ELE_W-1:0] cur_ele_r, anchor_ele_r, trail_ele_r;
  logic                      cur_last_r;
  logic                      have_first_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_lat_r  <= in_lat;
      cur_lon_r  <= in_lon;
      cur_ele_r  <= in_ele;
      cur_last_r <= in_last;
    end
    if (cmd.load_first || cmd.acc_add) begin
      trail_lat_r <= cur_lat_r;
      trail_lon_r <= cur_lon_r;
      trail_ele_r <= cur_ele_r;
    end
    if (cmd.load_first) begin
      anchor_lat_r <= cur_lat_r;
      anchor_lon_r <= cur_lon_r;
      anchor_ele_r <= cur_ele_r;
    end
  end

  // coordinate difference magnitudes
  logic [tla_pkg::LAT_W-1:0] ref_lat;
  logic [tla_pkg::LON_W-1:0] ref_lon;
  logic [tla_pkg::ELE_W-1:0] ref_ele;
  logic [MLAT_W-1:0] dlat, mlat_r;
  logic [MLON_W-1:0] dlon, mlon_r;
  logic [MELE_W-1:0] dele, mele_r;

  always_comb begin
    ref_lat = cmd.sel_first ? anchor_lat_r : trail_lat_r;
    ref_lon = cmd.sel_first ? anchor_lon_r : trail_lon_r;
    ref_ele = cmd.sel_first ? anchor_ele_r : trail_ele_r;
    dlat = {cur_lat_r[tla_pkg::LAT_W-1], cur_lat_r} - {ref_lat[tla_pkg::LAT_W-1], ref_lat};
    dlon = {cur_lon_r[tla_pkg::LON_W-1], cur_lon_r} - {ref_lon[tla_pkg::LON_W-1], ref_lon};
    dele = {cur_ele_r[tla_pkg::ELE_W-1], cur_ele_r} - {ref_ele[tla_pkg::ELE_W-1], ref_ele};
  end

  always_ff @(posedge clk) begin
    if (cmd.do_diff) begin
      mlat_r <= dlat[MLAT_W-1] ? -dlat : dlat;
      mlon_r <= dlon[MLON_W-1] ? -dlon : dlon;
      mele_r <= dele[MELE_W-1] ? -dele : dele;
    end
  end

  // scale to millimetres, truncating the fraction
  logic [PY_W-1:0] prod_y;
  logic [PX_W-1:0] prod_x;
  logic [V_W-1:0]  vy_r, vx_r, vz_r;

  assign prod_y = PY_W'(mlat_r) * PY_W'(lat_scale_r);
  assign prod_x = PX_W'(mlon_r) * PX_W'(lon_scale_r);

  always_ff @(posedge clk) begin
    if (cmd.do_scale) begin
      vy_r <= V_W'(prod_y >> SCALE_FRAC_BITS);
      vx_r <= V_W'(prod_x >> SCALE_FRAC_BITS);
      vz_r <= V_W'(mele_r);
    end
  end

  // sum of squares, one half-width partial product per cycle
  logic [V_W-1:0]  sq_v;
  logic [H-1:0]    sq_lo, sq_hi, sq_a, sq_b;
  logic [2*H-1:0]  sq_prod;
  logic [SH_W-1:0] sq_sh;
  logic [SQ_W-1:0] sq_term, sum_r;

  always_comb begin
    unique case (cmd.sq_var)
      tla_pkg::VAR_Y: sq_v = vy_r;
      tla_pkg::VAR_X: sq_v = vx_r;
      default:        sq_v = vz_r;
    endcase
    sq_lo = sq_v[H-1:0];
    sq_hi = H'(sq_v >> H);
    unique case (cmd.sq_part)
      tla_pkg::PART_LL: begin sq_a = sq_lo; sq_b = sq_lo; sq_sh = '0; end
      tla_pkg::PART_LH: begin sq_a = sq_lo; sq_b = sq_hi; sq_sh = SH_W'(H + 1); end
      tla_pkg::PART_HH: begin sq_a = sq_hi; sq_b = sq_hi; sq_sh = SH_W'(2 * H); end
      default:          begin sq_a = '0;    sq_b = '0;    sq_sh = '0; end
    endcase
    sq_prod = (2*H)'(sq_a) * (2*H)'(sq_b);
    sq_term = SQ_W'(sq_prod) << sq_sh;
  end

  always_ff @(posedge clk) begin
    if (cmd.do_scale) begin
      sum_r <= '0;
    end else if (cmd.do_sq) begin
      sum_r <= sum_r + sq_term;
    end
  end

  // restoring square root, one root bit per cycle
  logic [SQ_W-1:0]   rad_r;
  logic [RM_W-1:0]   rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [RM_W+1:0]   rem_sh, trial;

  assign rem_sh = {rem_r, rad_r[SQ_W-1 -: 2]};
  assign trial  = (RM_W+2)'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rad_r  <= sum_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= RM_W'(rem_sh - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= RM_W'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // saturating length accumulator
  logic [tla_pkg::LEN_W-1:0] acc_r;
  logic                      seg_clip;

  assign seg_clip = CW'(root_r) >= (CW'(tla_pkg::LEN_MAX) - CW'(acc_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      have_first_r <= 1'b0;
    end else if (cmd.clear_track) begin
      acc_r        <= '0;
      have_first_r <= 1'b0;
    end else begin
      if (cmd.load_first) have_first_r <= 1'b1;
      if (cmd.acc_add) acc_r <= seg_clip ? tla_pkg::LEN_MAX : acc_r + tla_pkg::LEN_W'(root_r);
    end
  end

  // direct distance and ratio divider
  logic [tla_pkg::DIR_W-1:0]   direct_r, drem_r;
  logic                        dsat_r;
  logic [tla_pkg::RATIO_W-1:0] num_r, quot_r;
  logic [tla_pkg::DIR_W:0]     dsh;

  assign dsh = {drem_r, num_r[tla_pkg::RATIO_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.dir_load) begin
      if (DW'(root_r) > DW'(tla_pkg::DIR_MAX)) begin
        direct_r <= tla_pkg::DIR_MAX;
        dsat_r   <= 1'b1;
      end else begin
        direct_r <= tla_pkg::DIR_W'(root_r);
        dsat_r   <= 1'b0;
      end
      drem_r <= tla_pkg::DIR_W'(acc_r[tla_pkg::LEN_W-1:tla_pkg::RATIO_FRAC]);
      num_r  <= {acc_r[tla_pkg::RATIO_FRAC-1:0], {tla_pkg::RATIO_FRAC{1'b0}}};
      quot_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= num_r << 1;
      if (dsh >= {1'b0, direct_r}) begin
        drem_r <= tla_pkg::DIR_W'(dsh - {1'b0, direct_r});
        quot_r <= {quot_r[tla_pkg::RATIO_W-2:0], 1'b1};
      end else begin
        drem_r <= tla_pkg::DIR_W'(dsh);
        quot_r <= {quot_r[tla_pkg::RATIO_W-2:0], 1'b0};
      end
    end
  end

  logic dir_zero, ratio_ovf;
  assign dir_zero  = (direct_r == '0);
  assign ratio_ovf = tla_pkg::DIR_W'(acc_r[tla_pkg::LEN_W-1:tla_pkg::RATIO_FRAC]) >= direct_r;

  // result register
  logic                        out_valid_r;
  logic [tla_pkg::LEN_W-1:0]   res_len_r;
  logic [tla_pkg::DIR_W-1:0]   res_dir_r;
  logic [tla_pkg::RATIO_W-1:0] res_ratio_r;
  logic                        res_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_len_r   <= acc_r;
      res_dir_r   <= direct_r;
      res_ratio_r <= dir_zero ? '0 : (ratio_ovf ? tla_pkg::RATIO_MAX : quot_r);
      res_sat_r   <= (acc_r == tla_pkg::LEN_MAX) || dsat_r || (!dir_zero && ratio_ovf);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_ratio_r, res_dir_r, res_len_r};
  assign out_tuser  = res_sat_r;

  assign sts.have_first = have_first_r;
  assign sts.last       = cur_last_r;
  assign sts.out_busy   = out_valid_r && !out_tready;
  assign sts.dir_zero   = dir_zero;
  assign sts.ratio_ovf  = ratio_ovf;

endmodule

### hdl/tla_ctrl.sv
// tla_ctrl: state machine sequencing distance, accumulate, divide and result steps.
// Depends on tla_pkg.
module tla_ctrl #(
  parameter int ROOT_W = 42
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  tla_pkg::sts_t sts,
  output tla_pkg::cmd_t cmd
);

  localparam int CNT_W = $clog2(ROOT_W);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_SCALE = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_SQI   = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_SEG   = 4'd7;
  localparam logic [3:0] S_DIR   = 4'd8;
  localparam logic [3:0] S_CHK   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       var_r, var_nxt, part_r, part_nxt;
  logic             phase_r, phase_nxt;   // 1 while working on the direct distance

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      var_r   <= tla_pkg::VAR_Y;
      part_r  <= tla_pkg::PART_LL;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      var_r   <= var_nxt;
      part_r  <= part_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    var_nxt   = var_r;
    part_nxt  = part_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.sel_first = phase_r;
    cmd.sq_var    = var_r;
    cmd.sq_part   = part_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_START;
      end
      S_START: begin
        if (!sts.have_first) begin
          cmd.load_first = 1'b1;
          phase_nxt = 1'b1;
          state_nxt = sts.last ? S_DIFF : S_IDLE;
        end else begin
          phase_nxt = 1'b0;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.do_diff = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.do_scale = 1'b1;
        var_nxt  = tla_pkg::VAR_Y;
        part_nxt = tla_pkg::PART_LL;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.do_sq = 1'b1;
        if (part_r == tla_pkg::PART_HH) begin
          part_nxt = tla_pkg::PART_LL;
          var_nxt  = var_r + 2'd1;
          if (var_r == tla_pkg::VAR_Z) state_nxt = S_SQI;
        end else begin
          part_nxt = part_r + 2'd1;
        end
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) state_nxt = phase_r ? S_DIR : S_SEG;
      end
      S_SEG: begin
        cmd.acc_add = 1'b1;
        phase_nxt = 1'b1;
        state_nxt = sts.last ? S_DIFF : S_IDLE;
      end
      S_DIR: begin
        cmd.dir_load = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cnt_nxt = '0;
        state_nxt = (sts.dir_zero || sts.ratio_ovf) ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(tla_pkg::DIV_STEPS - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out    = 1'b1;
          cmd.clear_track = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### hdl/track_length_accumulator.sv
// track_length_accumulator: top level, joins controller and datapath.
// Depends on tla_pkg, tla_ctrl, tla_dpath.
//
// Usage: track points come in one word at a time on the in_ stream; in_tlast
// marks the last point of a track. Each point after the first adds the 3D
// distance to the previous point to a saturating total. On the last point one
// result word leaves on the out_ stream: total length, direct distance first
// to last point and their Q16 ratio; out_tuser flags a clipped value. The
// track then clears and the next word starts a new one.
// Timing: a first point that is not last is only stored; every other point
// runs through the bit-serial square root, which produces one root bit per
// cycle after nine squaring steps on one shared multiplier. A last point after
// the first runs the root twice (a single point track runs it once) and then
// the divider, one quotient bit per cycle.
// The result sits in an output register, so the next track is taken while it
// waits; if the receiver still stalls when the next result is ready, the block
// holds that result and takes no input. Reset (rst_n low, synchronous) empties
// the track and restores the scale registers to their defaults. Scale registers
// are written on cfg_we only while the block is idle, a rule the user enforces.
module track_length_accumulator #(
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // latitude [30:0], longitude [62:31], elevation [87:63]
  input  logic [tla_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // track_length_mm [47:0], direct_distance_mm [87:48], ratio_q16 [119:88]
  output logic [tla_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // saturated [0]
  output logic                                out_tuser,
  input  logic                                cfg_we,
  input  logic [tla_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tla_pkg::CFG_W-1:0]           cfg_data
);

  // widest scaled coordinate difference plus one gives the root width
  localparam int ROOT_W = tla_pkg::LON_W + 1 + tla_pkg::CFG_W - SCALE_FRAC_BITS + 1;

  tla_pkg::cmd_t cmd;
  tla_pkg::sts_t sts;
  logic          in_fire;

  assign in_fire = in_tvalid && in_tready;

  tla_ctrl #(
    .ROOT_W (ROOT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tla_dpath #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
    .ROOT_W          (ROOT_W)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_lat     (in_tdata[30:0]),
    .in_lon     (in_tdata[62:31]),
    .in_ele     (in_tdata[87:63]),
    .in_last    (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
